FILE: hw/rtl/ecpm_pkg.sv
// ----------------------------------------------------------------------------
// ecpm_pkg
// Shared types and constants of the pin edge counter and PWM meter.
// ----------------------------------------------------------------------------
package ecpm_pkg;

  // configuration register map
  localparam int unsigned REG_EDGE_MODE   = 0;
  localparam int unsigned NUM_REGS        = 1;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;
  localparam int unsigned MODE_W          = 3;
  localparam logic [MODE_W-1:0] EDGE_MODE_RESET = 3'd3;

  // edge mode codes
  localparam logic [MODE_W-1:0] MODE_RISE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FALL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PWM  = 3'd4;

  // action codes of an input item
  localparam logic ACTION_EDGE = 1'b0;
  localparam logic ACTION_ACK  = 1'b1;

  // measurement constants
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned DUTY_W           = 7;
  localparam int unsigned FREQ_OUT_W       = 20;
  localparam int unsigned DUTY_SCALE       = 100;
  localparam int unsigned FREQ_MAX         = 1048575;
  localparam int unsigned DUTY_DIVIDEND_W  = TIME_W + DUTY_W;
  localparam int unsigned TICKS_DEFAULT    = 1000000;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic              action;
    logic              level;
    logic [TIME_W-1:0] time_us;
  } edge_item_t;

  typedef struct packed {
    logic [31:0]           rise_count;
    logic [31:0]           fall_count;
    logic                  rises_enabled;
    logic                  falls_enabled;
    logic [DUTY_W-1:0]     duty_percent;
    logic [FREQ_OUT_W-1:0] frequency_hz;
    logic                  notify;
  } result_item_t;

  // classified command between front and back
  typedef enum logic [2:0] {
    CMD_ACK,
    CMD_COUNT_RISE,
    CMD_COUNT_FALL,
    CMD_SKIP,
    CMD_PWM_RISE,
    CMD_PWM_FALL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

endpackage

FILE: hw/rtl/ecpm_front.sv
// ----------------------------------------------------------------------------
// ecpm_front
// Accepts edge and acknowledge items and classifies them against the mode.
// ----------------------------------------------------------------------------
module ecpm_front import ecpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] edge_mode,
  input  logic              edge_valid,
  output logic              edge_stall,
  input  edge_item_t        edge_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_kind_t kind;
  logic      take;

  // classify the incoming item
  always_comb begin
    if (edge_item.action == ACTION_ACK) begin
      kind = CMD_ACK;
    end else if (edge_mode == MODE_PWM) begin
      kind = edge_item.level ? CMD_PWM_RISE : CMD_PWM_FALL;
    end else if (edge_mode == MODE_RISE && !edge_item.level) begin
      kind = CMD_SKIP;
    end else if (edge_mode == MODE_FALL && edge_item.level) begin
      kind = CMD_SKIP;
    end else begin
      kind = edge_item.level ? CMD_COUNT_RISE : CMD_COUNT_FALL;
    end
  end

  assign edge_stall = cmd_valid && !cmd_ready;
  assign take       = edge_valid && !edge_stall;

  // command holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd.kind    <= kind;
      cmd.time_us <= edge_item.time_us;
    end
  end

endmodule

FILE: hw/rtl/ecpm_queue.sv
// ----------------------------------------------------------------------------
// ecpm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ecpm_queue import ecpm_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/ecpm_div.sv
// ----------------------------------------------------------------------------
// ecpm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecpm_div import ecpm_pkg::*; #(
  parameter int unsigned N = DUTY_DIVIDEND_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [N-1:0]      dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              busy,
  output logic [N-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(N);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [CNT_W-1:0]  count;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem, quotient[N-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_W'(N - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quotient <= {quotient[N-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/ecpm_back.sv
// ----------------------------------------------------------------------------
// ecpm_back
// Executes commands: edge counters, notify flag, PWM timing and results.
// ----------------------------------------------------------------------------
module ecpm_back import ecpm_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] edge_mode,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  cmd_t              cmd,
  output logic              result_valid,
  input  logic              result_stall,
  output result_item_t      result_item
);

  localparam int unsigned FREQ_W = $clog2(TICKS_PER_SECOND + 1);

  back_state_t state;
  back_state_t state_next;

  logic [31:0]           rises_total;
  logic [31:0]           falls_total;
  logic                  notice_pending;
  logic [TIME_W-1:0]     high_start_time;
  logic [TIME_W-1:0]     low_start_time;
  logic [TIME_W-1:0]     high_duration;
  logic [TIME_W-1:0]     low_duration;
  logic [DUTY_W-1:0]     duty_held;
  logic [FREQ_OUT_W-1:0] frequency_held;

  logic [31:0]           rises_total_next;
  logic [31:0]           falls_total_next;
  logic                  notice_pending_next;
  logic [TIME_W-1:0]     high_start_time_next;
  logic [TIME_W-1:0]     low_start_time_next;
  logic [TIME_W-1:0]     high_duration_next;
  logic [TIME_W-1:0]     low_duration_next;
  logic [DUTY_W-1:0]     duty_held_next;
  logic [FREQ_OUT_W-1:0] frequency_held_next;

  logic                  out_free;
  logic                  emit;
  logic                  notify;
  logic                  div_start;
  logic [TIME_W-1:0]     period_sum;
  logic [DUTY_DIVIDEND_W-1:0] high_scaled;
  logic                  f_busy;
  logic                  d_busy;
  logic [FREQ_W-1:0]     f_quot;
  logic [DUTY_DIVIDEND_W-1:0] d_quot;
  logic [31:0]           f_wide;

  assign out_free    = !result_valid || !result_stall;
  assign period_sum  = high_duration + low_duration;
  assign high_scaled = DUTY_DIVIDEND_W'(high_duration) * DUTY_DIVIDEND_W'(DUTY_SCALE);
  assign f_wide      = 32'(f_quot);

  // frequency and duty dividers run side by side
  ecpm_div #(.N(FREQ_W)) u_freq_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (FREQ_W'(TICKS_PER_SECOND)),
    .divisor  (period_sum),
    .busy     (f_busy),
    .quotient (f_quot)
  );

  ecpm_div #(.N(DUTY_DIVIDEND_W)) u_duty_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (high_scaled),
    .divisor  (period_sum),
    .busy     (d_busy),
    .quotient (d_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free && cmd.kind == CMD_PWM_RISE) begin
          state_next = ST_PERIOD;
        end
      end
      ST_PERIOD: begin
        state_next = (period_sum == '0) ? ST_EMIT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!f_busy && !d_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command execution and result assembly
  always_comb begin
    cmd_pop              = 1'b0;
    emit                 = 1'b0;
    notify               = 1'b0;
    div_start            = 1'b0;
    rises_total_next     = rises_total;
    falls_total_next     = falls_total;
    notice_pending_next  = notice_pending;
    high_start_time_next = high_start_time;
    low_start_time_next  = low_start_time;
    high_duration_next   = high_duration;
    low_duration_next    = low_duration;
    duty_held_next       = duty_held;
    frequency_held_next  = frequency_held;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          emit    = 1'b1;
          case (cmd.kind) inside
            CMD_ACK: begin
              notice_pending_next = 1'b0;
            end
            CMD_COUNT_RISE, CMD_COUNT_FALL: begin
              if (cmd.kind == CMD_COUNT_RISE) begin
                rises_total_next = rises_total + 32'd1;
              end else begin
                falls_total_next = falls_total + 32'd1;
              end
              if (!notice_pending) begin
                notice_pending_next = 1'b1;
                notify              = 1'b1;
              end
            end
            CMD_PWM_FALL: begin
              high_duration_next  = cmd.time_us - high_start_time;
              low_start_time_next = cmd.time_us;
            end
            CMD_PWM_RISE: begin
              emit                 = 1'b0;
              low_duration_next    = cmd.time_us - low_start_time;
              high_start_time_next = cmd.time_us;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PERIOD: begin
        if (period_sum == '0) begin
          duty_held_next      = '0;
          frequency_held_next = '0;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (!f_busy && !d_busy) begin
          frequency_held_next = (f_wide > 32'(FREQ_MAX)) ? FREQ_OUT_W'(FREQ_MAX)
                                                         : f_wide[FREQ_OUT_W-1:0];
          duty_held_next = (d_quot > DUTY_DIVIDEND_W'(DUTY_SCALE)) ? DUTY_W'(DUTY_SCALE)
                                                                   : d_quot[DUTY_W-1:0];
        end
      end
      ST_EMIT: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  // control and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      rises_total     <= '0;
      falls_total     <= '0;
      notice_pending  <= 1'b0;
      high_start_time <= '0;
      low_start_time  <= '0;
      high_duration   <= '0;
      low_duration    <= '0;
      duty_held       <= '0;
      frequency_held  <= '0;
      result_valid    <= 1'b0;
    end else begin
      state           <= state_next;
      rises_total     <= rises_total_next;
      falls_total     <= falls_total_next;
      notice_pending  <= notice_pending_next;
      high_start_time <= high_start_time_next;
      low_start_time  <= low_start_time_next;
      high_duration   <= high_duration_next;
      low_duration    <= low_duration_next;
      duty_held       <= duty_held_next;
      frequency_held  <= frequency_held_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      result_item.rise_count    <= rises_total_next;
      result_item.fall_count    <= falls_total_next;
      result_item.rises_enabled <= edge_mode[0];
      result_item.falls_enabled <= edge_mode[1];
      result_item.duty_percent  <= duty_held_next;
      result_item.frequency_hz  <= frequency_held_next;
      result_item.notify        <= notify;
    end
  end

endmodule

FILE: hw/rtl/edge_counter_pwm_meter.sv
// ----------------------------------------------------------------------------
// edge_counter_pwm_meter
// Pin edge counter and PWM duty and frequency meter with an APB register.
// ----------------------------------------------------------------------------
// An accepted item passes the front holding register and the queue to the back,
// which writes the result register. A PWM rising edge result waits for the
// 39-bit duty divider, which retires one quotient bit per cycle. Counting
// items flow at one item per cycle while the result is not stalled; the back
// takes no command while it works on a PWM rising edge. Synchronous reset
// clears counters, timing and queue, and sets edge_mode to both edges.
module edge_counter_pwm_meter import ecpm_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               edge_valid,
  output logic               edge_stall,
  input  edge_item_t         edge_item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_item_t       result_item
);

  logic [MODE_W-1:0] edge_mode;
  logic              reg_write;
  logic              reg_hit;
  logic              f_valid;
  logic              q_ready;
  cmd_t              f_cmd;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_cmd;

  // configuration register
  assign pready    = 1'b1;
  assign reg_hit   = paddr[PADDR_W-1:2] == 1'(REG_EDGE_MODE);
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_hit ? PDATA_W'(edge_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_mode <= EDGE_MODE_RESET;
    end else if (reg_write && reg_hit) begin
      edge_mode <= pwdata[MODE_W-1:0];
    end
  end

  ecpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .edge_mode  (edge_mode),
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .edge_item  (edge_item),
    .cmd_valid  (f_valid),
    .cmd_ready  (q_ready),
    .cmd        (f_cmd)
  );

  ecpm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  ecpm_back #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_back (
    .clk          (clk),
    .rst          (rst),
    .edge_mode    (edge_mode),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .cmd          (q_cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

FILE: hw/rtl/ecpm_checker.sv
// ----------------------------------------------------------------------------
// ecpm_checker
// Port level checks of the edge counter and PWM meter.
// ----------------------------------------------------------------------------
module ecpm_checker import ecpm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               edge_valid,
  input logic               edge_stall,
  input logic               result_valid,
  input logic               result_stall,
  input result_item_t       result_item
);

  logic [7:0] outstanding;
  logic       in_take;
  logic       out_take;

  assign in_take  = edge_valid && !edge_stall;
  assign out_take = result_valid && !result_stall;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_take && !out_take) begin
      outstanding <= outstanding + 8'd1;
    end else if (out_take && !in_take) begin
      outstanding <= outstanding - 8'd1;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // every result belongs to an accepted item
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 8'd0)
    else $error("result without an accepted item");

  // duty never above full scale
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.duty_percent <= DUTY_W'(DUTY_SCALE))
    else $error("duty above full scale");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind edge_counter_pwm_meter ecpm_checker u_ecpm_checker (.*);
